/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/twram_pkg.sv */
// ----------------------------------------------------------------------------
// twram_pkg
// Types and constants for the two-wire register access master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twram_pkg;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_RESET    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [7:0] ADDR_WR_SET  = 8'h80;
  localparam logic [7:0] ADDR_WR_MASK = 8'hBF;
  localparam logic [7:0] ADDR_RD_SET  = 8'hC0;
  localparam logic [7:0] RST_ADDR     = 8'h8D;
  localparam logic [7:0] RST_DATA     = 8'h00;
  localparam logic [5:0] RESET_PULSES = 6'd32;
  localparam logic [5:0] BYTE_BITS    = 6'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PULSE_HI,
    PH_PULSE_LO,
    PH_WR_HI,
    PH_WR_LO,
    PH_RD_HI,
    PH_RD_LO
  } phase_t;

  typedef struct packed {
    logic       command_valid;
    logic [1:0] opcode;
    logic [5:0] reg_address;
    logic [7:0] write_data;
    logic       data_pin_in;
  } in_item_t;

  typedef struct packed {
    logic       clock_pin;
    logic       data_pin_out;
    logic       data_drive_enable;
    logic       busy_res;
    logic       read_done;
    logic [7:0] read_byte;
  } out_item_t;

endpackage

/* rtl/twram_seq.sv */
// ----------------------------------------------------------------------------
// twram_seq
// Pin sequencer: advances one tick per accepted item and forms the pin levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twram_seq
  import twram_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [15:0] half_period,
  input  in_item_t    item,
  output out_item_t   res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] half_cnt_r, half_cnt_nxt;
  logic [5:0]  bit_cnt_r, bit_cnt_nxt;
  logic        byte_idx_r, byte_idx_nxt;
  logic [7:0]  shift_out_r, shift_out_nxt;
  logic [7:0]  shift_in_r, shift_in_nxt;
  logic [1:0]  pend_op_r, pend_op_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        clk_pin_r, clk_pin_nxt;
  logic        dat_pin_r, dat_pin_nxt;
  logic        en_pin_r, en_pin_nxt;
  logic        done;
  logic [16:0] limit;
  logic [7:0]  shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      half_cnt_r  <= '0;
      bit_cnt_r   <= '0;
      byte_idx_r  <= 1'b0;
      shift_out_r <= '0;
      shift_in_r  <= '0;
      pend_op_r   <= OP_WRITE;
      held_r      <= '0;
      clk_pin_r   <= 1'b0;
      dat_pin_r   <= 1'b1;
      en_pin_r    <= 1'b1;
    end else if (step) begin
      phase_r     <= phase_nxt;
      half_cnt_r  <= half_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_idx_r  <= byte_idx_nxt;
      shift_out_r <= shift_out_nxt;
      shift_in_r  <= shift_in_nxt;
      pend_op_r   <= pend_op_nxt;
      held_r      <= held_nxt;
      clk_pin_r   <= clk_pin_nxt;
      dat_pin_r   <= dat_pin_nxt;
      en_pin_r    <= en_pin_nxt;
    end
  end

  // a zero setting behaves as a setting of one
  assign limit   = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
  assign shifted = {shift_out_r[6:0], 1'b0};

  always_comb begin
    phase_nxt     = phase_r;
    half_cnt_nxt  = half_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    byte_idx_nxt  = byte_idx_r;
    shift_out_nxt = shift_out_r;
    shift_in_nxt  = shift_in_r;
    pend_op_nxt   = pend_op_r;
    held_nxt      = held_r;
    clk_pin_nxt   = clk_pin_r;
    dat_pin_nxt   = dat_pin_r;
    en_pin_nxt    = en_pin_r;
    done          = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (item.command_valid && item.opcode != OP_RESERVED) begin
        pend_op_nxt  = item.opcode;
        byte_idx_nxt = 1'b0;
        half_cnt_nxt = '0;
        clk_pin_nxt  = 1'b1;
        en_pin_nxt   = 1'b1;
        if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
          held_nxt      = (item.opcode == OP_WRITE) ? item.write_data : RST_DATA;
          shift_out_nxt = (item.opcode == OP_WRITE)
                        ? ((ADDR_WR_SET | {2'b00, item.reg_address}) & ADDR_WR_MASK)
                        : (ADDR_RD_SET | {2'b00, item.reg_address});
          bit_cnt_nxt   = BYTE_BITS;
          phase_nxt     = PH_WR_HI;
          dat_pin_nxt   = shift_out_nxt[7];
        end else begin
          held_nxt    = RST_DATA;
          bit_cnt_nxt = RESET_PULSES;
          phase_nxt   = PH_PULSE_HI;
          dat_pin_nxt = 1'b0;
        end
      end
    end else if ({1'b0, half_cnt_r} + 17'd1 >= limit) begin
      half_cnt_nxt = '0;
      case (phase_r)
        PH_PULSE_HI: begin
          phase_nxt = PH_PULSE_LO;
          {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b001;
        end
        PH_PULSE_LO: begin
          if (bit_cnt_r <= 6'd1) begin
            // pulses done, write zero to the reset register
            byte_idx_nxt  = 1'b0;
            shift_out_nxt = RST_ADDR;
            bit_cnt_nxt   = BYTE_BITS;
            phase_nxt     = PH_WR_HI;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = {1'b1, RST_ADDR[7], 1'b1};
          end else begin
            bit_cnt_nxt = bit_cnt_r - 6'd1;
            phase_nxt   = PH_PULSE_HI;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b101;
          end
        end
        PH_WR_HI: begin
          phase_nxt = PH_WR_LO;
          {clk_pin_nxt, en_pin_nxt} = 2'b01;
        end
        PH_WR_LO: begin
          shift_out_nxt = shifted;
          if (bit_cnt_r > 6'd1) begin
            bit_cnt_nxt = bit_cnt_r - 6'd1;
            phase_nxt   = PH_WR_HI;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = {1'b1, shifted[7], 1'b1};
          end else if (!byte_idx_r && pend_op_r == OP_READ) begin
            bit_cnt_nxt = BYTE_BITS;
            phase_nxt   = PH_RD_HI;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b100;
          end else if (!byte_idx_r) begin
            byte_idx_nxt  = 1'b1;
            shift_out_nxt = held_r;
            bit_cnt_nxt   = BYTE_BITS;
            phase_nxt     = PH_WR_HI;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = {1'b1, held_r[7], 1'b1};
          end else begin
            bit_cnt_nxt = '0;
            phase_nxt   = PH_IDLE;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b101;
          end
        end
        PH_RD_HI: begin
          phase_nxt = PH_RD_LO;
          {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b000;
        end
        PH_RD_LO: begin
          // sample on the last tick of the low half
          shift_in_nxt = {shift_in_r[6:0], item.data_pin_in};
          if (bit_cnt_r > 6'd1) begin
            bit_cnt_nxt = bit_cnt_r - 6'd1;
            phase_nxt   = PH_RD_HI;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b100;
          end else begin
            bit_cnt_nxt = '0;
            phase_nxt   = PH_IDLE;
            done        = 1'b1;
            {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b101;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          {clk_pin_nxt, dat_pin_nxt, en_pin_nxt} = 3'b101;
        end
      endcase
    end else begin
      half_cnt_nxt = half_cnt_r + 16'd1;
    end
  end

  assign res.clock_pin         = clk_pin_nxt;
  assign res.data_pin_out      = en_pin_nxt & dat_pin_nxt;
  assign res.data_drive_enable = en_pin_nxt;
  assign res.busy_res          = (phase_nxt != PH_IDLE);
  assign res.read_done         = done;
  assign res.read_byte         = shift_in_nxt;

endmodule

/* rtl/two_wire_register_access_master.sv */
// the result item for an input item is presented in the cycle after it is accepted
// throughput: one item per cycle while in_stall is low, one sequencer step per accepted item
// in_stall rises only while a finished result is held against out_stall
// synchronous active-low reset: idle, pins clock 0 data 1 driven, half period 1
// ----------------------------------------------------------------------------
// two_wire_register_access_master
// Pin-level master for a two-wire register port, stepped once per input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_wire_register_access_master
  import twram_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [15:0] half_period_r;
  logic        in_acc;
  out_item_t   step_res;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  twram_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .half_period (half_period_r),
    .item        (in_data),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/twram_chk.sv */
// ----------------------------------------------------------------------------
// twram_chk
// Port-level checks on the two-wire register access master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twram_chk
  import twram_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic done_idle_ok;
  logic released_ok;

  // a finished read leaves the pins at rest
  assign done_idle_ok = !out_data.busy_res && out_data.clock_pin &&
                        out_data.data_drive_enable;
  assign released_ok  = !out_data.data_pin_out && out_data.busy_res;

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  `ASSERT_NXT(a_item_result, clk, rst_n, in_valid && !in_stall, out_valid)
  `ASSERT_IMP(a_done_idle, clk, rst_n, out_valid && out_data.read_done, done_idle_ok)
  `ASSERT_IMP(a_released, clk, rst_n, out_valid && !out_data.data_drive_enable, released_ok)

endmodule

bind two_wire_register_access_master twram_chk u_twram_chk (.*);
